[rtl/core/two_level_prefix_range_lookup_macros.svh]
// assertion macros shared by the lookup block
`ifndef TWO_LEVEL_PREFIX_RANGE_LOOKUP_MACROS_SVH
`define TWO_LEVEL_PREFIX_RANGE_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TPLR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define TPLR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tplr_pkg.sv]
`default_nettype none

package tplr_pkg;

    // default sizes of the index stores
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_SECONDS_DEF = 16;

    // fixed field widths
    localparam int CHAR_W  = 16;
    localparam int IDX_W   = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_HEAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY       = 2'd2;

    // result of the shared character compare
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

`default_nettype wire

[rtl/core/tplr_ram.sv]
`default_nettype none

module tplr_ram #(
    parameter int WIDTH = tplr_pkg::CHAR_W,
    parameter int DEPTH = tplr_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/tplr_cmp.sv]
`default_nettype none

module tplr_cmp (
    input  wire logic [tplr_pkg::CHAR_W-1:0] a,
    input  wire logic [tplr_pkg::CHAR_W-1:0] b,
    output tplr_pkg::cmp_res_t               res
);

    // one character compare, reused by both scans
    always_comb
    begin
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

`default_nettype wire

[rtl/core/two_level_prefix_range_lookup.sv]
// loads give no result; in_ready stays high between loads
// a query runs a head scan and, for a hit on an entry with slots and a word of more
// than one character, a slot scan; an empty index goes straight to a miss. The scans
// make one compare per cycle through one read port on each store
// one query in flight: in_ready stays low until its result is in the output register
// reset clears the sequencer, out_valid and entry_count; the stores are not cleared
`default_nettype none

`include "two_level_prefix_range_lookup_macros.svh"

module two_level_prefix_range_lookup #(
    parameter int MAX_ENTRIES = tplr_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_SECONDS = tplr_pkg::MAX_SECONDS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [tplr_pkg::COUNT_W-1:0]       cfg_wdata,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tplr_pkg::CMD_W-1:0]         cmd,
    input  wire logic [5:0]                         entry,
    input  wire logic [3:0]                         slot,
    input  wire logic [tplr_pkg::CHAR_W-1:0]        key_char,
    input  wire logic [tplr_pkg::IDX_W-1:0]         index_value,
    input  wire logic [4:0]                         second_count,
    input  wire logic [tplr_pkg::CHAR_W-1:0]        query_second,
    input  wire logic                               single_char_word,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    found,
    output logic [tplr_pkg::IDX_W-1:0]              start_index,
    output logic                                    end_known,
    output logic [tplr_pkg::IDX_W-1:0]              end_index
);

    localparam int CW     = tplr_pkg::CHAR_W;
    localparam int IW     = tplr_pkg::IDX_W;
    localparam int NW     = $clog2(MAX_ENTRIES + 1);
    localparam int EAW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SCW    = $clog2(MAX_SECONDS + 1);
    localparam int SJW    = (MAX_SECONDS > 1) ? $clog2(MAX_SECONDS) : 1;
    localparam int SDEPTH = MAX_ENTRIES * MAX_SECONDS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int HW     = SCW + IW + CW;
    localparam int SW     = IW + CW;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HSCAN  = 3'd1;
    localparam logic [2:0] ST_HNEXT  = 3'd2;
    localparam logic [2:0] ST_SSCAN  = 3'd3;
    localparam logic [2:0] ST_SNEXT  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // control registers
    logic [2:0]                   state_reg, state_next;
    logic [tplr_pkg::COUNT_W-1:0] entry_count_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         pend_reg, pend_next;

    // payload registers
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  idx_reg, idx_next;
    logic [EAW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0]  key_reg, key_next;
    logic [CW-1:0]  qsec_reg, qsec_next;
    logic           single_reg, single_next;
    logic [SAW-1:0] sbase_reg, sbase_next;
    logic [SCW-1:0] hsc_reg, hsc_next;
    logic [IW-1:0]  hstart_reg, hstart_next;
    logic [IW-1:0]  nstart_reg, nstart_next;
    logic           have_next_reg, have_next_next;
    logic [SCW-1:0] jdx_reg, jdx_next;
    logic [SJW-1:0] pj_reg, pj_next;
    logic [IW-1:0]  start_reg, start_next;
    logic [IW-1:0]  end_reg, end_next;
    logic           end_set_reg, end_set_next;
    logic           found_reg, found_next;
    logic           o_found_reg, o_found_next;
    logic [IW-1:0]  o_start_reg, o_start_next;
    logic           o_known_reg, o_known_next;
    logic [IW-1:0]  o_end_reg, o_end_next;

    // store ports
    logic           h_we;
    logic [EAW-1:0] h_waddr, h_raddr;
    logic [HW-1:0]  h_wdata, h_rdata;
    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;
    logic [SCW-1:0] sc_clamped;

    logic [CW-1:0]  hrd_char, srd_char, cmp_a, cmp_b;
    logic [IW-1:0]  hrd_start, srd_start;
    logic [SCW-1:0] hrd_sc;
    logic [NW-1:0]  n_clamped;
    logic           in_xfer, out_free;
    tplr_pkg::cmp_res_t cmp_res;

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // head store: slot count, start index, first character
    assign sc_clamped = (32'(second_count) > MAX_SECONDS) ? SCW'(MAX_SECONDS)
                                                          : SCW'(second_count);
    assign h_we    = in_xfer && (cmd == tplr_pkg::CMD_LOAD_HEAD)
                     && (32'(entry) < MAX_ENTRIES);
    assign h_waddr = EAW'(entry);
    assign h_wdata = {sc_clamped, index_value, key_char};
    assign h_raddr = (idx_reg < n_reg) ? EAW'(idx_reg) : '0;

    tplr_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_ENTRIES),
        .AW    (EAW)
    ) u_head_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    assign hrd_char  = h_rdata[CW-1:0];
    assign hrd_start = h_rdata[CW+IW-1:CW];
    assign hrd_sc    = h_rdata[HW-1:CW+IW];

    // second-character store, addressed as entry * MAX_SECONDS + slot
    assign s_we    = in_xfer && (cmd == tplr_pkg::CMD_LOAD_SECOND)
                     && (32'(entry) < MAX_ENTRIES) && (32'(slot) < MAX_SECONDS);
    assign s_waddr = SAW'(entry * MAX_SECONDS) + SAW'(slot);
    assign s_wdata = {index_value, key_char};
    assign s_raddr = (jdx_reg < hsc_reg) ? (sbase_reg + SAW'(jdx_reg)) : '0;

    tplr_ram #(
        .WIDTH (SW),
        .DEPTH (SDEPTH),
        .AW    (SAW)
    ) u_second_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign srd_char  = s_rdata[CW-1:0];
    assign srd_start = s_rdata[SW-1:CW];

    // shared compare, operands follow the active scan
    assign cmp_a = (state_reg == ST_SSCAN) ? srd_char : hrd_char;
    assign cmp_b = (state_reg == ST_SSCAN) ? qsec_reg : key_reg;

    tplr_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign n_clamped = (32'(entry_count_reg) > MAX_ENTRIES) ? NW'(MAX_ENTRIES)
                                                           : NW'(entry_count_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        key_next       = key_reg;
        qsec_next      = qsec_reg;
        single_next    = single_reg;
        sbase_next     = sbase_reg;
        hsc_next       = hsc_reg;
        hstart_next    = hstart_reg;
        nstart_next    = nstart_reg;
        have_next_next = have_next_reg;
        jdx_next       = jdx_reg;
        pj_next        = pj_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        end_set_next   = end_set_reg;
        found_next     = found_reg;
        o_found_next   = o_found_reg;
        o_start_next   = o_start_reg;
        o_known_next   = o_known_reg;
        o_end_next     = o_end_reg;

        // output transfer frees the result register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (cmd == tplr_pkg::CMD_QUERY))
                begin
                    n_next         = n_clamped;
                    key_next       = key_char;
                    qsec_next      = query_second;
                    single_next    = single_char_word;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    start_next     = '0;
                    end_next       = '0;
                    end_set_next   = 1'b0;
                    have_next_next = 1'b0;
                    state_next     = (n_clamped == '0) ? ST_FINISH : ST_HSCAN;
                end
            end

            ST_HSCAN:
            begin
                // issue the next head read
                pend_next = (idx_reg < n_reg);
                pidx_next = EAW'(idx_reg);
                if (idx_reg < n_reg)
                begin
                    idx_next = idx_reg + NW'(1);
                end
                // check the head entry read last cycle
                if (pend_reg && cmp_res.eq)
                begin
                    sbase_next     = SAW'(pidx_reg * MAX_SECONDS);
                    hsc_next       = hrd_sc;
                    hstart_next    = hrd_start;
                    have_next_next = ((NW'(pidx_reg) + NW'(1)) < n_reg);
                    state_next     = ST_HNEXT;
                end
                else if (pend_reg && ((NW'(pidx_reg) + NW'(1)) == n_reg))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_HNEXT:
            begin
                // read data now holds the following head entry
                nstart_next = hrd_start;
                found_next  = 1'b1;
                start_next  = hstart_reg;
                jdx_next    = '0;
                pend_next   = 1'b0;
                if (single_reg || (hsc_reg == '0))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SSCAN;
                end
            end

            ST_SSCAN:
            begin
                // issue the next slot read
                pend_next = (jdx_reg < hsc_reg);
                pj_next   = SJW'(jdx_reg);
                if (jdx_reg < hsc_reg)
                begin
                    jdx_next = jdx_reg + SCW'(1);
                end
                // check the slot read last cycle
                if (pend_reg)
                begin
                    start_next = srd_start;
                    if (cmp_res.eq)
                    begin
                        if ((SCW'(pj_reg) + SCW'(1)) < hsc_reg)
                        begin
                            state_next = ST_SNEXT;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    else if (cmp_res.gt)
                    begin
                        end_next     = srd_start;
                        end_set_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else if ((SCW'(pj_reg) + SCW'(1)) == hsc_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SNEXT:
            begin
                // exact match: end is the following slot's start
                end_next     = srd_start;
                end_set_next = 1'b1;
                state_next   = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_found_next   = found_reg;
                    o_start_next   = start_reg;
                    o_known_next   = end_set_reg || have_next_reg;
                    if (end_set_reg)
                    begin
                        o_end_next = end_reg;
                    end
                    else if (have_next_reg)
                    begin
                        o_end_next = nstart_reg - 32'd1;
                    end
                    else
                    begin
                        o_end_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            pend_reg        <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        pidx_reg      <= pidx_next;
        key_reg       <= key_next;
        qsec_reg      <= qsec_next;
        single_reg    <= single_next;
        sbase_reg     <= sbase_next;
        hsc_reg       <= hsc_next;
        hstart_reg    <= hstart_next;
        nstart_reg    <= nstart_next;
        have_next_reg <= have_next_next;
        jdx_reg       <= jdx_next;
        pj_reg        <= pj_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        end_set_reg   <= end_set_next;
        found_reg     <= found_next;
        o_found_reg   <= o_found_next;
        o_start_reg   <= o_start_next;
        o_known_reg   <= o_known_next;
        o_end_reg     <= o_end_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign found       = o_found_reg;
    assign start_index = o_start_reg;
    assign end_known   = o_known_reg;
    assign end_index   = o_end_reg;

    // checks on the sequencer
    `TPLR_ASSERT_NOW(a_head_pend_in_range, clk, rst_n,
        (state_reg == ST_HSCAN) && pend_reg, NW'(pidx_reg) < n_reg,
        "head scan compares an entry beyond the count in use")
    `TPLR_ASSERT_NOW(a_slot_scan_needs_slots, clk, rst_n,
        state_reg == ST_SSCAN, (hsc_reg != '0) && !single_reg && found_reg,
        "slot scan entered without slots or for a single character word")
    `TPLR_ASSERT_NEXT(a_empty_index_misses, clk, rst_n,
        in_xfer && (cmd == tplr_pkg::CMD_QUERY) && (n_clamped == '0),
        (state_reg == ST_FINISH) && !found_reg && !have_next_reg,
        "query on an empty index did not go straight to a miss")
    `TPLR_ASSERT_NEXT(a_finish_delivers, clk, rst_n,
        (state_reg == ST_FINISH) && out_free,
        out_valid_reg && (state_reg == ST_IDLE),
        "finished query did not load the result register")

endmodule

`default_nettype wire

[test/range_lookup_tb_pkg.sv]
package range_lookup_tb_pkg;

    import tplr_pkg::*;

    localparam int HEADS   = MAX_ENTRIES_DEF;
    localparam int SECONDS = MAX_SECONDS_DEF;

    // one input transfer, field by field
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [5:0]        entry;
        logic [3:0]        slot;
        logic [CHAR_W-1:0] key_char;
        logic [IDX_W-1:0]  index_value;
        logic [4:0]        second_count;
        logic [CHAR_W-1:0] query_second;
        logic              single_char_word;
    } lookup_cmd_t;

    // one result transfer
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  start_index;
        logic              end_known;
        logic [IDX_W-1:0]  end_index;
    } prefix_range_t;

    class range_scoreboard;

        // mirror of the index stores and the count register
        logic [CHAR_W-1:0] head_char [HEADS];
        logic [IDX_W-1:0]  head_base [HEADS];
        int unsigned       head_seconds [HEADS];
        logic [CHAR_W-1:0] second_char [HEADS*SECONDS];
        logic [IDX_W-1:0]  second_base [HEADS*SECONDS];
        int unsigned       entries_in_use = 0;

        prefix_range_t     expected_ranges [$];
        int                error_count = 0;

        function void set_entry_count(logic [COUNT_W-1:0] value);
            entries_in_use = (value > HEADS) ? HEADS : value;
        endfunction

        function int outstanding();
            return expected_ranges.size();
        endfunction

        // update the mirror on loads, work out the range on queries
        function void note_transfer(lookup_cmd_t t);
            int                hit;
            int unsigned       sc;
            int unsigned       base;
            bit                done;
            bit                last_set;
            logic [IDX_W-1:0]  first;
            logic [IDX_W-1:0]  last;
            logic [CHAR_W-1:0] c;
            hit = -1;
            done = 1'b0;
            last_set = 1'b0;
            first = '0;
            last = '0;
            case (t.cmd)
                CMD_LOAD_HEAD:
                begin
                    head_char[t.entry] = t.key_char;
                    head_base[t.entry] = t.index_value;
                    head_seconds[t.entry] = (t.second_count > SECONDS) ? SECONDS
                                                                       : t.second_count;
                end
                CMD_LOAD_SECOND:
                begin
                    second_char[t.entry * SECONDS + t.slot] = t.key_char;
                    second_base[t.entry * SECONDS + t.slot] = t.index_value;
                end
                CMD_QUERY:
                begin
                    // head scan, first match wins
                    for (int i = 0; i < entries_in_use; i++)
                    begin
                        if (hit < 0 && head_char[i] == t.key_char)
                            hit = i;
                    end
                    if (hit < 0)
                    begin
                        expected_ranges.push_back(prefix_range_t'{1'b0, '0, 1'b0, '0});
                    end
                    else
                    begin
                        sc = head_seconds[hit];
                        base = hit * SECONDS;
                        if (t.single_char_word || sc == 0)
                        begin
                            first = head_base[hit];
                        end
                        else
                        begin
                            // slot scan, stops on equal or greater
                            for (int j = 0; j < sc; j++)
                            begin
                                if (!done)
                                begin
                                    c = second_char[base + j];
                                    first = second_base[base + j];
                                    if (c == t.query_second)
                                    begin
                                        done = 1'b1;
                                        if (j + 1 < sc)
                                        begin
                                            last = second_base[base + j + 1];
                                            last_set = 1'b1;
                                        end
                                    end
                                    else if (c > t.query_second)
                                    begin
                                        done = 1'b1;
                                        last = first;
                                        last_set = 1'b1;
                                    end
                                end
                            end
                        end
                        // fall back to the next head entry, unknown past the last one
                        if (!last_set && hit + 1 < entries_in_use)
                        begin
                            last = head_base[hit + 1] - 32'd1;
                            last_set = 1'b1;
                        end
                        expected_ranges.push_back(prefix_range_t'{1'b1, first, last_set,
                                                                  last_set ? last : '0});
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one result with the oldest expected range
        function void check_range(prefix_range_t got);
            prefix_range_t want;
            if (expected_ranges.size() == 0)
            begin
                $error("range result with no query waiting");
                error_count++;
            end
            else
            begin
                want = expected_ranges.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    error_count++;
                end
                if (got.start_index !== want.start_index)
                begin
                    $error("start_index: expected %08h, got %08h",
                           want.start_index, got.start_index);
                    error_count++;
                end
                if (got.end_known !== want.end_known)
                begin
                    $error("end_known: expected %0d, got %0d", want.end_known, got.end_known);
                    error_count++;
                end
                if (got.end_index !== want.end_index)
                begin
                    $error("end_index: expected %08h, got %08h", want.end_index, got.end_index);
                    error_count++;
                end
            end
        endfunction

    endclass

endpackage

[test/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tplr_pkg::*;
    import range_lookup_tb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam int IDLE_GAP    = 100;        // longest query latency plus margin
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1050;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd = '0;
    logic [5:0]           entry = '0;
    logic [3:0]           slot = '0;
    logic [CHAR_W-1:0]    key_char = '0;
    logic [IDX_W-1:0]     index_value = '0;
    logic [4:0]           second_count = '0;
    logic [CHAR_W-1:0]    query_second = '0;
    logic                 single_char_word = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 found;
    logic [IDX_W-1:0]     start_index;
    logic                 end_known;
    logic [IDX_W-1:0]     end_index;

    range_scoreboard      sb = new;
    bit                   calm = 1'b0;
    int                   hold_request = 0;
    int                   items_sent = 0;
    int                   live_entries = 0;
    int                   built_slots [HEADS];
    int unsigned          cycle_count = 0;

    two_level_prefix_range_lookup u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .entry            (entry),
        .slot             (slot),
        .key_char         (key_char),
        .index_value      (index_value),
        .second_count     (second_count),
        .query_second     (query_second),
        .single_char_word (single_char_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .start_index      (start_index),
        .end_known        (end_known),
        .end_index        (end_index)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 12);
        end
    end

    // result transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_range(prefix_range_t'{found, start_index, end_known, end_index});
    end

    // random filler for the fields a command does not use
    function automatic lookup_cmd_t noise_item(logic [CMD_W-1:0] code);
        lookup_cmd_t t;
        t.cmd = code;
        t.entry = 6'($urandom_range(0, 63));
        t.slot = 4'($urandom_range(0, 15));
        t.key_char = 16'($urandom);
        t.index_value = $urandom;
        t.second_count = 5'($urandom_range(0, 31));
        t.query_second = 16'($urandom);
        t.single_char_word = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input lookup_cmd_t t);
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= t.cmd;
        entry <= t.entry;
        slot <= t.slot;
        key_char <= t.key_char;
        index_value <= t.index_value;
        second_count <= t.second_count;
        query_second <= t.query_second;
        single_char_word <= t.single_char_word;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_transfer(t);
        items_sent++;
    endtask

    task automatic load_head(input int e, input logic [CHAR_W-1:0] key,
                             input logic [IDX_W-1:0] start, input int count);
        lookup_cmd_t t;
        t = noise_item(CMD_LOAD_HEAD);
        t.entry = 6'(e);
        t.key_char = key;
        t.index_value = start;
        t.second_count = 5'(count);
        send_item(t);
    endtask

    task automatic load_second(input int e, input int s, input logic [CHAR_W-1:0] key,
                               input logic [IDX_W-1:0] start);
        lookup_cmd_t t;
        t = noise_item(CMD_LOAD_SECOND);
        t.entry = 6'(e);
        t.slot = 4'(s);
        t.key_char = key;
        t.index_value = start;
        send_item(t);
    endtask

    task automatic query(input logic [CHAR_W-1:0] key, input logic [CHAR_W-1:0] second,
                         input logic single);
        lookup_cmd_t t;
        t = noise_item(CMD_QUERY);
        t.key_char = key;
        t.query_second = second;
        t.single_char_word = single;
        send_item(t);
    endtask

    // stop offering, wait for every result and for the block to go quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [COUNT_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_entry_count(value);
        live_entries = (value > HEADS) ? HEADS : int'(value);
    endtask

    // known index exercising each branch of the lookup
    task automatic run_directed();
        // empty index after reset
        query(16'h0061, 16'h0064, 1'b0);
        write_entry_count(7'd4);
        load_head(0, 16'h0061, 32'h0000_0010, 3);
        load_second(0, 0, 16'h0062, 32'h0000_0010);
        load_second(0, 1, 16'h0064, 32'h0000_0014);
        load_second(0, 2, 16'h0066, 32'h0000_0018);
        // next start of zero makes the end wrap
        load_head(1, 16'hFFFF, 32'h0000_0000, 0);
        // duplicate first char, shadowed by entry 0
        load_head(2, 16'h0061, 32'h0000_0200, 1);
        load_second(2, 0, 16'h0078, 32'h0000_0200);
        load_head(3, 16'h0000, 32'hFFFF_FFFF, 1);
        load_second(3, 0, 16'h006D, 32'hFFFF_FFFF);
        // equal in the middle, equal on the last slot, greater, all below, below first
        query(16'h0061, 16'h0064, 1'b0);
        query(16'h0061, 16'h0066, 1'b0);
        query(16'h0061, 16'h0063, 1'b0);
        query(16'h0061, 16'hFFFF, 1'b0);
        query(16'h0061, 16'h0000, 1'b0);
        // one-char word, entry without slots
        query(16'h0061, 16'h0064, 1'b1);
        query(16'hFFFF, 16'h0064, 1'b0);
        // last entry: end unknown
        query(16'h0000, 16'h006D, 1'b0);
        query(16'h0000, 16'h007A, 1'b1);
        // first char absent, then an unused command
        query(16'h0071, 16'h0061, 1'b0);
        send_item(noise_item(CMD_IGNORED));
    endtask

    // fresh index over every entry in use, mostly well-formed
    task automatic build_index();
        int                count;
        int                width;
        bit                heads_first;
        bit                scrambled;
        logic [CHAR_W-1:0] head_key;
        logic [CHAR_W-1:0] second_key;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  head_pos;
        logic [IDX_W-1:0]  slot_pos;
        pos = $urandom;
        for (int e = 0; e < live_entries; e++)
        begin
            // mostly few slots, now and then full or oversized counts
            case ($urandom_range(0, (live_entries > 16) ? 29 : 9))
                0: count = SECONDS;
                1: count = $urandom_range(SECONDS + 1, 31);
                default: count = $urandom_range(0, (live_entries > 16) ? 2 : 5);
            endcase
            width = (count > SECONDS) ? SECONDS : count;
            head_key = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'(16'h0040 + $urandom_range(0, 47));
            head_pos = ($urandom_range(0, 19) == 0) ? $urandom : pos;
            slot_pos = head_pos;
            heads_first = 1'($urandom_range(0, 1));
            scrambled = ($urandom_range(0, 9) == 0);
            if (heads_first)
                load_head(e, head_key, head_pos, count);
            second_key = 16'($urandom_range(0, 40));
            for (int s = 0; s < width; s++)
            begin
                if (scrambled)
                    second_key = 16'($urandom_range(0, 90));
                else if (s > 0)
                    second_key = second_key + 16'($urandom_range(0, 4));
                load_second(e, s, second_key, slot_pos);
                slot_pos = slot_pos + 32'($urandom_range(0, 3));
            end
            if (!heads_first)
                load_head(e, head_key, head_pos, count);
            built_slots[e] = width;
            pos = slot_pos + 32'($urandom_range(1, 40));
        end
    endtask

    // mostly queries aimed at stored prefixes, with reloads and noise
    task automatic run_random(input int count);
        int                pick;
        int                e;
        int                s;
        int                sc;
        logic [CHAR_W-1:0] second;
        for (int k = 0; k < count; k++)
        begin
            if (items_sent >= ITEM_TARGET)
                break;
            pick = $urandom_range(0, 99);
            if (pick < 68 && live_entries > 0)
            begin
                e = $urandom_range(0, live_entries - 1);
                sc = sb.head_seconds[e];
                second = 16'($urandom_range(0, 90));
                if (sc > 0)
                begin
                    s = $urandom_range(0, sc - 1);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: second = sb.second_char[e * SECONDS + s];
                        5: second = sb.second_char[e * SECONDS + s] + 16'd1;
                        6: second = sb.second_char[e * SECONDS + s] - 16'd1;
                        7: second = 16'($urandom);
                        default: ;
                    endcase
                end
                query(sb.head_char[e], second, $urandom_range(0, 99) < 15);
            end
            else if (pick < 78)
            begin
                // slot reload, often extending an entry's written slots
                if (live_entries > 0 && $urandom_range(0, 1))
                begin
                    e = $urandom_range(0, live_entries - 1);
                    s = (built_slots[e] < SECONDS) ? built_slots[e]
                                                   : $urandom_range(0, SECONDS - 1);
                end
                else
                begin
                    e = $urandom_range(0, HEADS - 1);
                    s = $urandom_range(0, SECONDS - 1);
                end
                load_second(e, s, 16'($urandom_range(0, 90)), $urandom);
                if (e < live_entries && s == built_slots[e])
                    built_slots[e]++;
            end
            else if (pick < 88)
            begin
                // head reload, slot count kept within written slots when in use
                if (live_entries > 0 && ($urandom_range(0, 1) || live_entries == HEADS))
                begin
                    e = $urandom_range(0, live_entries - 1);
                    sc = (built_slots[e] == SECONDS) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, built_slots[e]);
                end
                else
                begin
                    e = $urandom_range(live_entries, HEADS - 1);
                    sc = $urandom_range(0, 31);
                end
                load_head(e, 16'(16'h0040 + $urandom_range(0, 47)), $urandom, sc);
            end
            else if (pick < 93)
            begin
                send_item(noise_item(CMD_IGNORED));
            end
            else
            begin
                query(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // main sequence
    initial
    begin
        int                 phase;
        logic [COUNT_W-1:0] count_value;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 6)
                0: count_value = 7'($urandom_range(2, 8));
                1: count_value = 7'd64;
                2: count_value = 7'($urandom_range(2, 12));
                3: count_value = 7'd0;
                4: count_value = 7'd1;
                default: count_value = $urandom_range(0, 1) ? 7'd127
                                                             : 7'($urandom_range(65, 126));
            endcase
            write_entry_count(count_value);
            // one stretch with no idle cycles on either side
            calm = (phase == 1);
            build_index();
            // long result hold-off while queries keep coming
            if (phase == 2)
                hold_request = 300;
            run_random($urandom_range(60, 110));
            phase++;
        end
        drain();
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tplr_pkg.sv
rtl/core/tplr_ram.sv
rtl/core/tplr_cmp.sv
rtl/core/two_level_prefix_range_lookup.sv
test/range_lookup_tb_pkg.sv
test/testbench.sv
